/* hdl/lcc_pkg.sv */
// Shared types, constants and the control store of the levitation current compensator.
// Used by lcc_seq, the top level and the checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SETPOINT    = 3'd0;
    localparam logic [2:0] CFG_GAIN_E      = 3'd1;
    localparam logic [2:0] CFG_GAIN_PE     = 3'd2;
    localparam logic [2:0] CFG_GAIN_PU     = 3'd3;
    localparam logic [2:0] CFG_WINDOW_LOW  = 3'd4;
    localparam logic [2:0] CFG_WINDOW_HIGH = 3'd5;
    localparam logic [2:0] CFG_DEADBAND    = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_SETPOINT    = 16'd25559;
    localparam logic [31:0] RST_GAIN_E      = 32'd17026253;
    localparam logic [31:0] RST_GAIN_PE     = 32'd139329;
    localparam logic [31:0] RST_GAIN_PU     = 32'd27315;
    localparam logic [11:0] RST_WINDOW_LOW  = 12'd2000;
    localparam logic [11:0] RST_WINDOW_HIGH = 12'd2900;
    localparam logic [15:0] RST_DEADBAND    = 16'd3277;

    // Clamp state codes and the duty ceiling.
    localparam logic [1:0]  CLAMP_NONE = 2'd0;
    localparam logic [1:0]  CLAMP_ZERO = 2'd1;
    localparam logic [1:0]  CLAMP_MAX  = 2'd2;
    localparam logic [11:0] DUTY_MAX   = 12'd2192;

    // Multiplier constants. Reciprocals are floor(2^36/4095) and floor(2^38/1000).
    localparam logic signed [32:0] K_MV_SCALE   = 33'sd3300;
    localparam logic signed [32:0] K_RECIP_4095 = 33'sd16781313;
    localparam logic signed [32:0] K_FB_SLOPE   = 33'sd60948;
    localparam logic signed [32:0] K_RECIP_1000 = 33'sd274877906;
    localparam logic signed [32:0] K_SMALL      = 33'sd6554;
    localparam logic signed [32:0] K_DUTY_SLOPE = 33'sd4651000;

    localparam logic [27:0]        K_RND_500      = 28'd500;
    localparam logic signed [20:0] K_FB_OFFSET    = 21'sd171442;
    localparam logic [38:0]        K_DUTY_OFFSET  = 39'd13065654176;
    localparam logic signed [49:0] U_MAX          = 50'sd2147483648;
    localparam logic signed [49:0] U_MIN          = -50'sd2147483648;
    localparam logic signed [33:0] C_MAX          = 34'sd52428;

    localparam int STEP_W = 5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LD_NUM,
        OP_DIV4095,
        OP_LD_NUM_RND,
        OP_DIV1000,
        OP_LD_E,
        OP_ACC_LD,
        OP_ACC_SUB,
        OP_SAT,
        OP_LD_C,
        OP_LD_NUM_DUTY,
        OP_FIN_IN,
        OP_FIN_OUT
    } t_op;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_SAMP_SCALE,
        MS_PROD_R4095,
        MS_Q_SLOPE,
        MS_NUM_R1000,
        MS_B0_E,
        MS_B1_PE,
        MS_A1_PU,
        MS_U_SMALL,
        MS_C_SLOPE
    } t_mul;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_OUTSIDE,
        JC_CLAMP
    } t_jc;

    typedef struct packed {
        t_op              op;
        t_mul             mul;
        t_jc              jc;
        logic [STEP_W-1:0] target;
        logic             done;
    } t_ctrl;

    typedef struct packed {
        logic outside;
        logic clamp;
        logic out_free;
    } t_status;

    localparam logic [STEP_W-1:0] STEP_FIN_IN  = 5'd19;
    localparam logic [STEP_W-1:0] STEP_FIN_OUT = 5'd20;

    function automatic t_ctrl cw(input t_op op, input t_mul mul, input t_jc jc,
                                 input logic [STEP_W-1:0] target, input logic done);
        t_ctrl w;
        w.op     = op;
        w.mul    = mul;
        w.jc     = jc;
        w.target = target;
        w.done   = done;
        return w;
    endfunction

    // Control store. Each word names the datapath action, the product started, any conditional jump and the done flag.
    function automatic t_ctrl prog_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        case (step)
            5'd0:  w = cw(OP_NOP,         MS_SAMP_SCALE, JC_NONE,    '0, 1'b0);
            5'd1:  w = cw(OP_LD_NUM,      MS_PROD_R4095, JC_NONE,    '0, 1'b0);
            5'd2:  w = cw(OP_DIV4095,     MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd3:  w = cw(OP_NOP,         MS_Q_SLOPE,    JC_OUTSIDE, STEP_FIN_OUT, 1'b0);
            5'd4:  w = cw(OP_LD_NUM_RND,  MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd5:  w = cw(OP_NOP,         MS_NUM_R1000,  JC_NONE,    '0, 1'b0);
            5'd6:  w = cw(OP_DIV1000,     MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd7:  w = cw(OP_LD_E,        MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd8:  w = cw(OP_NOP,         MS_B0_E,       JC_NONE,    '0, 1'b0);
            5'd9:  w = cw(OP_ACC_LD,      MS_B1_PE,      JC_NONE,    '0, 1'b0);
            5'd10: w = cw(OP_ACC_SUB,     MS_A1_PU,      JC_NONE,    '0, 1'b0);
            5'd11: w = cw(OP_ACC_SUB,     MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd12: w = cw(OP_SAT,         MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd13: w = cw(OP_NOP,         MS_U_SMALL,    JC_NONE,    '0, 1'b0);
            5'd14: w = cw(OP_LD_C,        MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd15: w = cw(OP_NOP,         MS_C_SLOPE,    JC_CLAMP,   STEP_FIN_IN, 1'b0);
            5'd16: w = cw(OP_LD_NUM_DUTY, MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd17: w = cw(OP_NOP,         MS_NUM_R1000,  JC_NONE,    '0, 1'b0);
            5'd18: w = cw(OP_DIV1000,     MS_NONE,       JC_NONE,    '0, 1'b0);
            5'd19: w = cw(OP_FIN_IN,      MS_NONE,       JC_NONE,    '0, 1'b1);
            default: w = cw(OP_FIN_OUT,   MS_NONE,       JC_NONE,    '0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/lcc_seq.sv */
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on lcc_pkg for the control word, status struct and program.
`timescale 1ns / 1ps
`default_nettype none

module lcc_seq
    import lcc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output logic         o_busy,
    output t_ctrl        o_ctrl
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              take;
    t_ctrl             ctrl;

    assign ctrl   = prog_word(r_step);
    assign o_ctrl = ctrl;
    assign o_busy = r_busy;

    always_comb begin
        case (ctrl.jc)
            JC_OUTSIDE: take = i_status.outside;
            JC_CLAMP:   take = i_status.clamp;
            default:    take = 1'b0;
        endcase
        n_step = take ? ctrl.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end else if (ctrl.done) begin
            // The last word waits here until the output register can take the item.
            if (i_status.out_free) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

/* hdl/levitation_current_compensator_unit.sv */
// Top level of the levitation current compensator: configuration registers,
// datapath with one shared multiplier, and the result register. Uses lcc_pkg and lcc_seq.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The input channel carries one 12-bit sensor sample per item; the output channel
// carries duty, in_window and clamp_state for that item. Both channels use valid
// and stall: an item moves at a clock edge with valid high and stall low.
// A microprogram of 21 control words drives the datapath, which shares one
// registered 33 x 33 bit multiplier; a new sample waits until the last is done.
// An accepted sample runs 20 steps when the loop runs and the current is linear,
// 17 steps when the current clamps and 5 steps when the sample is outside the
// window. The result is valid on the cycle after the last step, and the next item
// can be accepted in the cycle after the result register loads. The input stall is
// high while a sample is being worked on.
// When the receiver stalls, the result waits in the output register while the
// next sample is accepted and worked on; that sample holds at its last step until
// the register is free. Configuration writes are taken at any edge with the write
// enable high and must only come while the block is idle.
// Reset (synchronous, active low) restores all register defaults, clears the
// stored error and output, empties the result register and idles the sequencer.

module levitation_current_compensator_unit
    import lcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [11:0] i_adc_sample,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [11:0]      o_duty,
    output logic             o_in_window,
    output logic [1:0]       o_clamp_state,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_setpoint;
    logic [31:0] r_gain_e;
    logic [31:0] r_gain_pe;
    logic [31:0] r_gain_pu;
    logic [11:0] r_win_lo;
    logic [11:0] r_win_hi;
    logic [15:0] r_deadband;

    // Compensator state carried from one item to the next.
    logic signed [19:0] r_prev_e;
    logic signed [32:0] r_prev_u;

    // Datapath registers.
    logic [11:0]        r_samp;
    logic signed [65:0] r_prod;
    logic [27:0]        r_num;
    logic [17:0]        r_q;
    logic signed [19:0] r_e;
    logic signed [49:0] r_acc;
    logic signed [32:0] r_u;
    logic               r_small;
    logic signed [33:0] r_c;

    // Result register.
    logic        r_out_valid;
    logic [11:0] r_duty;
    logic        r_in_win;
    logic [1:0]  r_clamp;

    logic    busy;
    logic    accept;
    logic    exec;
    t_ctrl   ctrl;
    t_status status;

    assign accept = i_in_valid && !busy;
    assign exec   = busy && (!ctrl.done || status.out_free);

    lcc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_status (status),
        .o_busy   (busy),
        .o_ctrl   (ctrl)
    );

    // Shared multiplier operand selection.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;

    always_comb begin
        case (ctrl.mul)
            MS_SAMP_SCALE: begin
                mul_a = {21'b0, r_samp};
                mul_b = K_MV_SCALE;
            end
            MS_PROD_R4095: begin
                mul_a = {1'b0, r_prod[31:0]};
                mul_b = K_RECIP_4095;
            end
            MS_Q_SLOPE: begin
                mul_a = {15'b0, r_q};
                mul_b = K_FB_SLOPE;
            end
            MS_NUM_R1000: begin
                mul_a = {5'b0, r_num};
                mul_b = K_RECIP_1000;
            end
            MS_B0_E: begin
                mul_a = {1'b0, r_gain_e};
                mul_b = {{13{r_e[19]}}, r_e};
            end
            MS_B1_PE: begin
                mul_a = {1'b0, r_gain_pe};
                mul_b = {{13{r_prev_e[19]}}, r_prev_e};
            end
            MS_A1_PU: begin
                mul_a = {1'b0, r_gain_pu};
                mul_b = r_prev_u;
            end
            MS_U_SMALL: begin
                mul_a = r_u;
                mul_b = K_SMALL;
            end
            MS_C_SLOPE: begin
                mul_a = r_c[32:0];
                mul_b = K_DUTY_SLOPE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product shifted down by 16 with floor rounding.
    logic signed [65:0] prod_sh;
    assign prod_sh = r_prod >>> 16;

    // Division by a constant: the reciprocal product gives a quotient that is
    // exact or one short, and a single remainder compare corrects it.
    logic [17:0] q0;
    logic [27:0] qk;
    logic [27:0] rem;
    logic [27:0] divisor;

    always_comb begin
        if (ctrl.op == OP_DIV4095) begin
            q0      = r_prod[53:36];
            divisor = 28'd4095;
        end else begin
            q0      = r_prod[55:38];
            divisor = 28'd1000;
        end
        qk  = 28'(q0) * divisor;
        rem = r_num - qk;
    end

    // Error, saturation and deadband.
    logic signed [20:0] e_full;
    logic signed [32:0] sat_u;
    logic [19:0]        e_mag;
    logic signed [33:0] c_add;
    logic [38:0]        duty_num;

    assign e_full   = K_FB_OFFSET - $signed({3'b0, r_q}) - $signed({5'b0, r_setpoint});
    assign e_mag    = r_e[19] ? 20'(-r_e) : r_e;
    assign c_add    = r_small ? prod_sh[33:0] : {r_u[32], r_u};
    assign duty_num = r_prod[38:0] + K_DUTY_OFFSET;

    always_comb begin
        if (r_acc > U_MAX) begin
            sat_u = U_MAX[32:0];
        end else if (r_acc < U_MIN) begin
            sat_u = U_MIN[32:0];
        end else begin
            sat_u = r_acc[32:0];
        end
    end

    logic c_le0;
    logic c_hi;
    assign c_le0 = (r_c <= 34'sd0);
    assign c_hi  = (r_c > C_MAX);

    assign status.outside  = !((r_q[11:0] > r_win_lo) && (r_q[11:0] < r_win_hi));
    assign status.clamp    = c_le0 || c_hi;
    assign status.out_free = !r_out_valid || !i_out_stall;

    // Control state: configuration, compensator state and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= RST_SETPOINT;
            r_gain_e    <= RST_GAIN_E;
            r_gain_pe   <= RST_GAIN_PE;
            r_gain_pu   <= RST_GAIN_PU;
            r_win_lo    <= RST_WINDOW_LOW;
            r_win_hi    <= RST_WINDOW_HIGH;
            r_deadband  <= RST_DEADBAND;
            r_prev_e    <= '0;
            r_prev_u    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SETPOINT:    r_setpoint <= i_cfg_data[15:0];
                    CFG_GAIN_E:      r_gain_e   <= i_cfg_data;
                    CFG_GAIN_PE:     r_gain_pe  <= i_cfg_data;
                    CFG_GAIN_PU:     r_gain_pu  <= i_cfg_data;
                    CFG_WINDOW_LOW:  r_win_lo   <= i_cfg_data[11:0];
                    CFG_WINDOW_HIGH: r_win_hi   <= i_cfg_data[11:0];
                    CFG_DEADBAND:    r_deadband <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // A finishing item refills the result register; otherwise an accepted
            // result empties it.
            if (exec && (ctrl.op == OP_FIN_IN || ctrl.op == OP_FIN_OUT)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (exec) begin
                case (ctrl.op)
                    OP_SAT: begin
                        r_prev_e <= r_e;
                        r_prev_u <= sat_u;
                    end
                    OP_FIN_OUT: begin
                        r_prev_e <= '0;
                        r_prev_u <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath and result payload.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (accept) begin
            r_samp <= i_adc_sample;
        end

        if (exec) begin
            case (ctrl.op)
                OP_LD_NUM:      r_num <= r_prod[27:0];
                OP_LD_NUM_RND:  r_num <= r_prod[27:0] + K_RND_500;
                OP_LD_NUM_DUTY: r_num <= {6'b0, duty_num[38:17]};
                OP_DIV4095,
                OP_DIV1000:     r_q   <= q0 + 18'(rem >= divisor);
                OP_LD_E:        r_e   <= e_full[19:0];
                OP_ACC_LD:      r_acc <= prod_sh[49:0];
                OP_ACC_SUB:     r_acc <= r_acc - prod_sh[49:0];
                OP_SAT: begin
                    r_u     <= sat_u;
                    r_small <= (e_mag < {4'b0, r_deadband});
                end
                OP_LD_C:        r_c   <= $signed({18'b0, r_setpoint}) + c_add;
                OP_FIN_IN: begin
                    r_in_win <= 1'b1;
                    if (c_le0) begin
                        r_duty  <= '0;
                        r_clamp <= CLAMP_ZERO;
                    end else if (c_hi) begin
                        r_duty  <= DUTY_MAX;
                        r_clamp <= CLAMP_MAX;
                    end else begin
                        r_duty  <= r_q[11:0];
                        r_clamp <= CLAMP_NONE;
                    end
                end
                OP_FIN_OUT: begin
                    r_duty   <= '0;
                    r_in_win <= 1'b0;
                    r_clamp  <= CLAMP_NONE;
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall    = busy;
    assign o_out_valid   = r_out_valid;
    assign o_duty        = r_duty;
    assign o_in_window   = r_in_win;
    assign o_clamp_state = r_clamp;

endmodule

`default_nettype wire

/* hdl/lcc_chk.sv */
// Port-level checker for the levitation current compensator, bound to the top level.
// Depends on lcc_pkg for the clamp codes and the duty ceiling.
`timescale 1ns / 1ps
`default_nettype none

module lcc_chk
    import lcc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [11:0] o_duty,
    input wire logic        o_in_window,
    input wire logic [1:0]  o_clamp_state
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_duty) && $stable(o_in_window) && $stable(o_clamp_state))
        else $error("result changed while stalled");

    // A sample outside the window gives an all-zero result.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_window |-> o_duty == '0 && o_clamp_state == CLAMP_NONE)
        else $error("out-of-window result is not zero");

    // Clamp codes agree with the duty value.
    a_clamp_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_window |->
            (o_clamp_state == CLAMP_ZERO && o_duty == '0) ||
            (o_clamp_state == CLAMP_MAX && o_duty == DUTY_MAX) ||
            (o_clamp_state == CLAMP_NONE && o_duty < DUTY_MAX))
        else $error("clamp state and duty disagree");

    // An accepted item keeps the input side stalled on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an accepted item");

endmodule

bind levitation_current_compensator_unit lcc_chk u_lcc_chk (.*);

`default_nettype wire
